/* rtl/khpi_pkg.sv */
// shared types and constants for the keyframe hermite path interpolator
package khpi_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned SEG_W        = 6;
  localparam int unsigned PARAM_W      = 17;
  localparam int unsigned KCOUNT_W     = 7;
  localparam int unsigned KEY_WORDS    = 9;
  localparam int unsigned KEY_DATA_W   = KEY_WORDS * DATA_W;

  localparam logic [KCOUNT_W-1:0] KCOUNT_RST = 7'd2;
  localparam logic [PARAM_W-1:0]  PARAM_ONE  = 17'h10000;

  // sequencing lengths
  localparam int unsigned FETCH_STEPS = 3;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned BASIS_STEPS = 3;
  localparam int unsigned DOT_TERMS   = 12;

  // func codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic       load_t;
    logic       scan_eval;
    logic       scan_first;
    logic       scan_last;
    logic       fetch_lo;
    logic       fetch_hi;
    logic       cap0;
    logic       cap1;
    logic       prep;
    logic       div_step;
    logic       u2_step;
    logic       u3_step;
    logic       h_step;
    logic       mul_en;
    logic [3:0] mul_idx;
    logic       acc_en;
  } cmd_t;

endpackage

/* rtl/khpi_ram.sv */
// generic single write port ram with registered read
module khpi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/khpi_ctrl.sv */
// controller state machine for the keyframe hermite path interpolator
module khpi_ctrl #(
  parameter int unsigned MaxKeys = khpi_pkg::MAX_KEYS_DEF,
  localparam int unsigned AddrW = $clog2(MaxKeys)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          func_i,
  input  logic                          cfg_valid_i,
  input  logic [khpi_pkg::KCOUNT_W-1:0] cfg_data_i,
  output logic                          cfg_ready_o,
  output logic                          busy_o,
  output logic                          done_o,
  output khpi_pkg::cmd_t                cmd_o,
  output logic [AddrW-1:0]              scan_addr_o
);
  import khpi_pkg::*;

  localparam int unsigned CntNW = $clog2(MaxKeys + 1);
  localparam int unsigned CntW  = (CntNW > 5) ? CntNW : 5;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_FETCH = 8'b0000_0100,
    ST_PREP  = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_BASIS = 8'b0010_0000,
    ST_DOT   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [KCOUNT_W-1:0] kcount_q;
  logic [CntW-1:0]     n_keys;

  // key count register, ready only while idle with no transaction offered
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcount_q <= KCOUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      kcount_q <= cfg_data_i;
    end
  end

  // keys in use, clamped to [2, MaxKeys]
  always_comb begin
    if (kcount_q < KCOUNT_W'(2)) begin
      n_keys = CntW'(2);
    end else if (int'(kcount_q) > int'(MaxKeys)) begin
      n_keys = CntW'(MaxKeys);
    end else begin
      n_keys = CntW'(kcount_q);
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    scan_addr_o = cnt_q[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start_i && (func_i == FUNC_QUERY)) begin
          cmd_o.load_t = 1'b1;
          cnt_d        = '0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_eval  = (cnt_q != '0);
        cmd_o.scan_first = (cnt_q == CntW'(1));
        cmd_o.scan_last  = (cnt_q == n_keys);
        if (cnt_q == n_keys) begin
          cnt_d   = '0;
          state_d = ST_FETCH;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_FETCH: begin
        cmd_o.fetch_lo = (cnt_q == CntW'(0));
        cmd_o.fetch_hi = (cnt_q == CntW'(1));
        cmd_o.cap0     = (cnt_q == CntW'(1));
        cmd_o.cap1     = (cnt_q == CntW'(FETCH_STEPS - 1));
        if (cnt_q == CntW'(FETCH_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_PREP;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_BASIS;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_BASIS: begin
        cmd_o.u2_step = (cnt_q == CntW'(0));
        cmd_o.u3_step = (cnt_q == CntW'(1));
        cmd_o.h_step  = (cnt_q == CntW'(BASIS_STEPS - 1));
        if (cnt_q == CntW'(BASIS_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_DOT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_DOT: begin
        cmd_o.mul_en  = (cnt_q < CntW'(DOT_TERMS));
        cmd_o.mul_idx = cnt_q[3:0];
        cmd_o.acc_en  = (cnt_q != '0);
        if (cnt_q == CntW'(DOT_TERMS)) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  // checks
  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> (state_q == ST_IDLE))
    else $error("result strobe not followed by idle");

  a_query_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i && func_i == FUNC_QUERY)
      |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("query transaction did not start the scan");

  a_scan_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= n_keys))
    else $error("scan ran past the last key");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && start_i && func_i == FUNC_LOAD) |=> !busy_o)
    else $error("load transaction made the block busy");

endmodule

/* rtl/khpi_dp.sv */
// datapath: key tables, segment search, divider, hermite basis and dot products
module khpi_dp #(
  parameter int unsigned MaxKeys = khpi_pkg::MAX_KEYS_DEF,
  localparam int unsigned AddrW = $clog2(MaxKeys)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_en_i,
  input  logic [khpi_pkg::SLOT_W-1:0]  slot_i,
  input  logic signed [31:0]           stamp_i,
  input  logic [khpi_pkg::KEY_DATA_W-1:0] key_data_i,
  input  khpi_pkg::cmd_t               cmd_i,
  input  logic [AddrW-1:0]             scan_addr_i,
  output logic signed [31:0]           out_x_o,
  output logic signed [31:0]           out_y_o,
  output logic signed [31:0]           out_z_o,
  output logic [khpi_pkg::SEG_W-1:0]   segment_o,
  output logic [khpi_pkg::PARAM_W-1:0] local_param_o
);
  import khpi_pkg::*;

  localparam int unsigned HW   = 34;
  localparam int unsigned PW   = 53;
  localparam int unsigned ProdW = HW + DATA_W;
  localparam int unsigned AccW = ProdW + 2;

  // round a q0.48 basis value half up to q0.32
  function automatic logic signed [HW-1:0] to_q32(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    y = (x + PW'(32768)) >>> 16;
    return y[HW-1:0];
  endfunction

  logic                      we;
  logic [AddrW-1:0]          waddr, raddr, raddr_q, seg_q;
  logic signed [31:0]        tdat;
  logic [KEY_DATA_W-1:0]     ddat;

  logic signed [31:0]        t_q, prev_q, t0_q, t1_q;
  logic                      found_q, below_q;
  logic [KEY_DATA_W-1:0]     d0_q, d1_q;
  logic signed [32:0]        num, dt;
  logic [32:0]               dt_q;
  logic [33:0]               rem_q, rem2;
  logic                      div_mode_q, ge;
  logic [PARAM_W-1:0]        u_q;
  logic [33:0]               u2_q;
  logic [50:0]               u3_q;
  logic signed [PW-1:0]      a3, b2, uq32;
  logic signed [HW-1:0]      h_q [4];
  logic signed [HW-1:0]      h_sel;
  logic signed [31:0]        v_sel;
  logic [1:0]                axis, term;
  logic signed [ProdW-1:0]   prod_q;
  logic [3:0]                acc_idx_q;
  logic signed [AccW-1:0]    acc_q, acc_sum, rnd;
  logic signed [31:0]        sat;

  // key tables
  assign we    = load_en_i && (int'(slot_i) < int'(MaxKeys));
  assign waddr = AddrW'(slot_i);

  always_comb begin
    if (cmd_i.fetch_hi) begin
      raddr = seg_q + AddrW'(1);
    end else if (cmd_i.fetch_lo) begin
      raddr = seg_q;
    end else begin
      raddr = scan_addr_i;
    end
  end

  khpi_ram #(.Width(DATA_W), .Depth(MaxKeys)) u_time_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(stamp_i),
    .raddr_i(raddr),
    .rdata_o(tdat)
  );

  khpi_ram #(.Width(KEY_DATA_W), .Depth(MaxKeys)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(key_data_i),
    .raddr_i(raddr),
    .rdata_o(ddat)
  );

  // search control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      below_q <= 1'b0;
    end else if (cmd_i.scan_eval && cmd_i.scan_first) begin
      found_q <= (t_q < tdat);
      below_q <= (t_q < tdat);
    end else if (cmd_i.scan_eval && !found_q && prev_q <= t_q && t_q <= tdat) begin
      found_q <= 1'b1;
    end
  end

  // segment search, time capture
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    if (cmd_i.load_t) begin
      t_q <= stamp_i;
    end
    if (cmd_i.scan_eval) begin
      prev_q <= tdat;
      if (cmd_i.scan_first) begin
        seg_q <= '0;
      end else begin
        if (!found_q && prev_q <= t_q && t_q <= tdat) begin
          seg_q <= raddr_q - AddrW'(1);
        end
        if (cmd_i.scan_last && !below_q && (t_q >= tdat || !found_q)) begin
          seg_q <= raddr_q - AddrW'(1);
        end
      end
    end
    if (cmd_i.cap0) begin
      t0_q <= tdat;
      d0_q <= ddat;
    end
    if (cmd_i.cap1) begin
      t1_q <= tdat;
      d1_q <= ddat;
    end
  end

  // segment offsets
  assign num  = 33'(t_q) - 33'(t0_q);
  assign dt   = 33'(t1_q) - 33'(t0_q);
  assign rem2 = {rem_q[32:0], 1'b0};
  assign ge   = (rem2 >= {1'b0, dt_q});

  // local parameter: special cases, then restoring divide one bit a step
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dt_q       <= dt;
      rem_q      <= 34'(num);
      div_mode_q <= 1'b0;
      u_q        <= '0;
      if (dt > 33'sd0 && num > 33'sd0) begin
        if (num >= dt) begin
          u_q <= PARAM_ONE;
        end else begin
          div_mode_q <= 1'b1;
        end
      end
    end else if (cmd_i.div_step && div_mode_q) begin
      rem_q <= ge ? (rem2 - {1'b0, dt_q}) : rem2;
      u_q   <= {u_q[PARAM_W-2:0], ge};
    end
  end

  // hermite basis in q0.48, rounded to q0.32
  assign a3   = PW'(u3_q);
  assign b2   = PW'({u2_q, 16'b0});
  assign uq32 = PW'({u_q, 32'b0});

  always_ff @(posedge clk_i) begin
    if (cmd_i.u2_step) begin
      u2_q <= u_q * u_q;
    end
    if (cmd_i.u3_step) begin
      u3_q <= u2_q * u_q;
    end
    if (cmd_i.h_step) begin
      h_q[0] <= to_q32((a3 <<< 1) - 3 * b2 + (PW'(1) <<< 48));
      h_q[1] <= to_q32(a3 - (b2 <<< 1) + uq32);
      h_q[2] <= to_q32(3 * b2 - (a3 <<< 1));
      h_q[3] <= to_q32(a3 - b2);
    end
  end

  // operand select for one product
  assign axis = cmd_i.mul_idx[3:2];
  assign term = cmd_i.mul_idx[1:0];

  always_comb begin
    h_sel = h_q[term];
    case (term)
      2'd0:    v_sel = d0_q[DATA_W * int'(axis) +: DATA_W];
      2'd1:    v_sel = d0_q[DATA_W * (3 + int'(axis)) +: DATA_W];
      2'd2:    v_sel = d1_q[DATA_W * int'(axis) +: DATA_W];
      default: v_sel = d1_q[DATA_W * (6 + int'(axis)) +: DATA_W];
    endcase
  end

  // accumulate, round half up to q16.16, saturate
  assign acc_sum = ((acc_idx_q[1:0] == 2'd0) ? AccW'(0) : acc_q) + AccW'(prod_q);
  assign rnd     = (acc_sum + (AccW'(1) <<< 31)) >>> 32;

  always_comb begin
    if (rnd > AccW'(32'sh7fff_ffff)) begin
      sat = 32'sh7fff_ffff;
    end else if (rnd < -(AccW'(1) <<< 31)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = rnd[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q    <= h_sel * v_sel;
      acc_idx_q <= cmd_i.mul_idx;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_sum;
      if (acc_idx_q[1:0] == 2'd3) begin
        case (acc_idx_q[3:2])
          2'd0:    out_x_o <= sat;
          2'd1:    out_y_o <= sat;
          2'd2:    out_z_o <= sat;
          default: ;
        endcase
      end
    end
  end

  assign segment_o     = SEG_W'(seg_q);
  assign local_param_o = u_q;

endmodule

/* rtl/keyframe_hermite_path_interp.sv */
// top level of the keyframe hermite path interpolator
// A load transaction (func 0) writes one keyframe slot in the cycle it is
// accepted and returns nothing; the block stays ready. A query transaction
// (func 1) runs a linear search over the active keys, one key time read per
// cycle from the time table, then fetches the two bracketing keys, runs a
// 16-step restoring divide for the local parameter, builds the four basis
// values and takes twelve products through one shared multiplier. The result
// is shown on the output ports for exactly one cycle with done_o high; the
// receiver cannot stall it, so it must be taken in that cycle. busy is high
// for the whole query. The key count is taken only while the block is idle
// and no transaction is offered on start. The key tables hold no reset:
// query only slots that were loaded.
module keyframe_hermite_path_interp #(
  parameter int unsigned MaxKeys = khpi_pkg::MAX_KEYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func_i,
  input  logic [khpi_pkg::SLOT_W-1:0]    slot_i,
  input  logic signed [31:0]             stamp_i,
  input  logic signed [31:0]             pos_x_i,
  input  logic signed [31:0]             pos_y_i,
  input  logic signed [31:0]             pos_z_i,
  input  logic signed [31:0]             tout_x_i,
  input  logic signed [31:0]             tout_y_i,
  input  logic signed [31:0]             tout_z_i,
  input  logic signed [31:0]             tin_x_i,
  input  logic signed [31:0]             tin_y_i,
  input  logic signed [31:0]             tin_z_i,
  output logic                           done_o,
  output logic signed [31:0]             out_x_o,
  output logic signed [31:0]             out_y_o,
  output logic signed [31:0]             out_z_o,
  output logic [khpi_pkg::SEG_W-1:0]     segment_o,
  output logic [khpi_pkg::PARAM_W-1:0]   local_param_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [khpi_pkg::KCOUNT_W-1:0]  cfg_data_i
);
  import khpi_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxKeys);

  cmd_t              cmd;
  logic [AddrW-1:0]  scan_addr;
  logic              load_en;
  logic [KEY_DATA_W-1:0] key_data;

  // load transaction accepted
  assign load_en  = start && !busy && (func_i == FUNC_LOAD);
  assign key_data = {tin_z_i, tin_y_i, tin_x_i, tout_z_i, tout_y_i, tout_x_i,
                     pos_z_i, pos_y_i, pos_x_i};

  khpi_ctrl #(.MaxKeys(MaxKeys)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .func_i     (func_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cfg_ready_o(cfg_ready_o),
    .busy_o     (busy),
    .done_o     (done_o),
    .cmd_o      (cmd),
    .scan_addr_o(scan_addr)
  );

  khpi_dp #(.MaxKeys(MaxKeys)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_en_i    (load_en),
    .slot_i       (slot_i),
    .stamp_i      (stamp_i),
    .key_data_i   (key_data),
    .cmd_i        (cmd),
    .scan_addr_i  (scan_addr),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .segment_o    (segment_o),
    .local_param_o(local_param_o)
  );

endmodule
